FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of this project.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AAVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AAVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/aavr_pkg.sv
// Types, widths and fixed-point constants for the axis-angle view rotation core.
// Used by aavr_cordic and axis_angle_view_rotation_core; no dependencies.
package aavr_pkg;

  // Field and datapath widths.
  localparam int ANGLE_W   = 16;  // input angle, Q2.13
  localparam int AXIS_W    = 16;  // axis components, Q1.14
  localparam int COORD_W   = 32;  // coordinates, Q16.16
  localparam int CFG_IDX_W = 3;   // register index on the configuration port
  localparam int TRIG_W    = 34;  // CORDIC x, y, z and cos/sin, Q30
  localparam int Q_W       = 32;  // axis products, Q28
  localparam int TQ_W      = 36;  // (1 - c) * axis products, Q30
  localparam int SUM_W     = 37;  // matrix entry before rounding, Q30
  localparam int M_W       = 31;  // rounded matrix entry, Q24
  localparam int D_W       = 33;  // view minus position, exact
  localparam int MUL_W     = 34;  // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 66;  // row accumulator
  localparam int FIN_W     = 43;  // row result before saturation

  // Shifts of the fixed-point formats.
  localparam int ANGLE_SHIFT = 17;  // Q13 to Q30
  localparam int S_SHIFT     = 14;  // axis * s, Q44 to Q30
  localparam int T_SHIFT     = 28;  // t * axis * axis, Q58 to Q30
  localparam int M_SHIFT     = 6;   // Q30 to Q24
  localparam int ROW_SHIFT   = 24;  // Q40 to Q16

  // Angle constants in Q30.
  localparam logic signed [TRIG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q30     = 34'sd1073741824;

  // Rounding offsets (half up).
  localparam logic signed [SUM_W-1:0] M_ROUND   = SUM_W'(1) <<< (M_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ROW_ROUND = ACC_W'(1) <<< (ROW_SHIFT - 1);

  // Arctangent steps for the first eleven iterations; later steps are powers of two.
  localparam logic signed [TRIG_W-1:0] ATAN_LO [11] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576
  };

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POS_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VIEW_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_VIEW_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_VIEW_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT        = 3'd6;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROT   = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // Operations of the shared multiplier, issued in this order.
  typedef enum logic [4:0] {
    OP_XS, OP_YS, OP_ZS,
    OP_QXX, OP_QXY, OP_QXZ, OP_QYY, OP_QYZ, OP_QZZ,
    OP_TXX, OP_TXY, OP_TXZ, OP_TYY, OP_TYZ, OP_TZZ,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8
  } op_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [TRIG_W-1:0] atan_step(input logic [4:0] i);
    logic signed [TRIG_W-1:0] r;
    r = '0;
    if (i < 5'd11) begin
      r = ATAN_LO[i[3:0]];
    end else if (i <= 5'd30) begin
      r = TRIG_W'(1) << (5'd30 - i);
    end
    return r;
  endfunction

  // Clamp a row result to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [FIN_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > FIN_W'(34'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -FIN_W'(34'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/aavr_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine, in Q30, of an angle in Q2.13.
// Depends on aavr_pkg for widths, angle constants and the arctangent steps.
module aavr_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [aavr_pkg::ANGLE_W-1:0]  angle,
  output logic                                 done,
  output logic signed [aavr_pkg::TRIG_W-1:0]   cos_q,
  output logic signed [aavr_pkg::TRIG_W-1:0]   sin_q
);
  import aavr_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

  logic                     busy;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic signed [TRIG_W-1:0] z;
  logic signed [TRIG_W-1:0] a_in;
  logic signed [TRIG_W-1:0] a_red;
  logic                     neg_in;
  logic signed [TRIG_W-1:0] x_sh;
  logic signed [TRIG_W-1:0] y_sh;
  logic signed [TRIG_W-1:0] at;
  logic signed [TRIG_W-1:0] x_nx;
  logic signed [TRIG_W-1:0] y_nx;
  logic signed [TRIG_W-1:0] z_nx;

  // Bring the angle to Q30 and fold it into [-pi/2, pi/2].
  always_comb begin
    a_in   = TRIG_W'(angle) <<< ANGLE_SHIFT;
    a_red  = a_in;
    neg_in = 1'b0;
    if (a_in > HALF_PI_Q30) begin
      a_red  = a_in - PI_Q30;
      neg_in = 1'b1;
    end else if (a_in < -HALF_PI_Q30) begin
      a_red  = a_in + PI_Q30;
      neg_in = 1'b1;
    end
  end

  // One micro-rotation; the sign of the residual angle picks the direction.
  always_comb begin
    x_sh = x >>> cnt;
    y_sh = y >>> cnt;
    at   = atan_step(5'(cnt));
    if (!z[TRIG_W-1]) begin
      x_nx = x - y_sh;
      y_nx = y + x_sh;
      z_nx = z - at;
    end else begin
      x_nx = x + y_sh;
      y_nx = y - x_sh;
      z_nx = z + at;
    end
  end

  // Control: a start loads the vector, the last step raises done for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= GAIN_Q30;
      y   <= '0;
      z   <= a_red;
      neg <= neg_in;
    end else if (busy) begin
      x <= x_nx;
      y <= y_nx;
      z <= z_nx;
      if (cnt == LAST) begin
        cos_q <= neg ? -x_nx : x_nx;
        sin_q <= neg ? -y_nx : y_nx;
      end
    end
  end

endmodule

FILE: hw/rtl/axis_angle_view_rotation_core.sv
// Axis-angle view rotation core: rotates the stored view point about the camera position.
// Each request runs the CORDIC iterations, then the 24 operations that issue one per cycle through
// the shared 34x34 multiplier; no new request is taken until the result is in the output register,
// and a result still stalled at the output holds the core until it is taken.
// Reset: synchronous; configuration, stored view point and sequencer go to zero and idle.
module axis_angle_view_rotation_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [aavr_pkg::ANGLE_W-1:0]     angle,
  input  logic signed [aavr_pkg::AXIS_W-1:0]      axis_x,
  input  logic signed [aavr_pkg::AXIS_W-1:0]      axis_y,
  input  logic signed [aavr_pkg::AXIS_W-1:0]      axis_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [aavr_pkg::COORD_W-1:0]     new_view_x,
  output logic signed [aavr_pkg::COORD_W-1:0]     new_view_y,
  output logic signed [aavr_pkg::COORD_W-1:0]     new_view_z,
  input  logic                                    cfg_we,
  input  logic [aavr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [aavr_pkg::COORD_W-1:0]            cfg_data
);
  import aavr_pkg::*;

  state_t state;
  op_t    op;
  op_t    op_nx;
  op_t    op_d;
  op_t    fin_op;
  logic   wb_v;
  logic   fin_v;
  logic   in_acc;
  logic   cfg_reload;

  // Configuration registers and stored view point.
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [COORD_W-1:0] start_view_x, start_view_y, start_view_z;
  logic signed [COORD_W-1:0] view_x, view_y, view_z;

  // Per-request operands and intermediate terms.
  logic signed [AXIS_W-1:0]  ax_r, ay_r, az_r;
  logic signed [D_W-1:0]     d_x, d_y, d_z;
  logic                      cor_done;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic signed [TRIG_W-1:0]  t_q;
  logic signed [TRIG_W-1:0]  xs_t, ys_t, zs_t;
  logic signed [Q_W-1:0]     q_xx, q_xy, q_xz, q_yy, q_yz, q_zz;
  logic signed [TQ_W-1:0]    t_xx, t_xy, t_xz, t_yy, t_yz, t_zz;
  logic signed [SUM_W-1:0]   m_sum;
  logic signed [SUM_W-1:0]   m_rnd;
  logic signed [M_W-1:0]     m_r;
  logic signed [MUL_W-1:0]   opa, opb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   rowsum;
  logic signed [COORD_W-1:0] pos_sel;
  logic signed [FIN_W-1:0]   fin_sum;
  logic signed [COORD_W-1:0] fin_sat;

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_reload = cfg_we && (cfg_index < REG_COUNT);
  assign op_nx      = op_t'(op + 5'd1);

  aavr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .angle (angle),
    .done  (cor_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_XS;
      wb_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wb_v <= (state == ST_MAC);
      // A new result is presented once the previous one has been taken.
      if ((state == ST_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cor_done) begin
            state <= ST_MAC;
            op    <= OP_XS;
          end
        end
        ST_MAC: begin
          if (op == OP_M8) begin
            state <= ST_DRAIN;
          end else begin
            op <= op_nx;
          end
        end
        ST_DRAIN: begin
          if (fin_v && (fin_op == OP_M8)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the axis and the offset of the view point from the position.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= axis_x;
      ay_r <= axis_y;
      az_r <= axis_z;
      d_x  <= D_W'(view_x) - D_W'(pos_x);
      d_y  <= D_W'(view_y) - D_W'(pos_y);
      d_z  <= D_W'(view_z) - D_W'(pos_z);
    end
    if ((state == ST_ROT) && cor_done) begin
      t_q <= ONE_Q30 - cos_q;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op)
      OP_XS:  begin opa = sin_q;          opb = MUL_W'(ax_r); end
      OP_YS:  begin opa = sin_q;          opb = MUL_W'(ay_r); end
      OP_ZS:  begin opa = sin_q;          opb = MUL_W'(az_r); end
      OP_QXX: begin opa = MUL_W'(ax_r);   opb = MUL_W'(ax_r); end
      OP_QXY: begin opa = MUL_W'(ax_r);   opb = MUL_W'(ay_r); end
      OP_QXZ: begin opa = MUL_W'(ax_r);   opb = MUL_W'(az_r); end
      OP_QYY: begin opa = MUL_W'(ay_r);   opb = MUL_W'(ay_r); end
      OP_QYZ: begin opa = MUL_W'(ay_r);   opb = MUL_W'(az_r); end
      OP_QZZ: begin opa = MUL_W'(az_r);   opb = MUL_W'(az_r); end
      OP_TXX: begin opa = t_q;            opb = MUL_W'(q_xx); end
      OP_TXY: begin opa = t_q;            opb = MUL_W'(q_xy); end
      OP_TXZ: begin opa = t_q;            opb = MUL_W'(q_xz); end
      OP_TYY: begin opa = t_q;            opb = MUL_W'(q_yy); end
      OP_TYZ: begin opa = t_q;            opb = MUL_W'(q_yz); end
      OP_TZZ: begin opa = t_q;            opb = MUL_W'(q_zz); end
      OP_M0, OP_M3, OP_M6: begin opa = MUL_W'(m_r); opb = MUL_W'(d_x); end
      OP_M1, OP_M4, OP_M7: begin opa = MUL_W'(m_r); opb = MUL_W'(d_y); end
      OP_M2, OP_M5, OP_M8: begin opa = MUL_W'(m_r); opb = MUL_W'(d_z); end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Matrix entry for the next operation, formed ahead of it from op_nx, registered and rounded to Q24.
  always_comb begin
    unique case (op_nx)
      OP_M0:   m_sum = SUM_W'(cos_q) + SUM_W'(t_xx);
      OP_M1:   m_sum = SUM_W'(t_xy) - SUM_W'(zs_t);
      OP_M2:   m_sum = SUM_W'(t_xz) + SUM_W'(ys_t);
      OP_M3:   m_sum = SUM_W'(t_xy) + SUM_W'(zs_t);
      OP_M4:   m_sum = SUM_W'(cos_q) + SUM_W'(t_yy);
      OP_M5:   m_sum = SUM_W'(t_yz) - SUM_W'(xs_t);
      OP_M6:   m_sum = SUM_W'(t_xz) - SUM_W'(ys_t);
      OP_M7:   m_sum = SUM_W'(t_yz) + SUM_W'(xs_t);
      OP_M8:   m_sum = SUM_W'(cos_q) + SUM_W'(t_zz);
      default: m_sum = '0;
    endcase
    m_rnd = (m_sum + M_ROUND) >>> M_SHIFT;
  end

  // Shared multiplier with registered product, and the matrix entry register.
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    m_r  <= M_W'(m_rnd);
    op_d <= op;
  end

  // Write-back of products into terms and row accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else begin
      fin_v <= 1'b0;
      if (wb_v) begin
        unique case (op_d)
          OP_XS:  xs_t <= prod[S_SHIFT+TRIG_W-1:S_SHIFT];
          OP_YS:  ys_t <= prod[S_SHIFT+TRIG_W-1:S_SHIFT];
          OP_ZS:  zs_t <= prod[S_SHIFT+TRIG_W-1:S_SHIFT];
          OP_QXX: q_xx <= prod[Q_W-1:0];
          OP_QXY: q_xy <= prod[Q_W-1:0];
          OP_QXZ: q_xz <= prod[Q_W-1:0];
          OP_QYY: q_yy <= prod[Q_W-1:0];
          OP_QYZ: q_yz <= prod[Q_W-1:0];
          OP_QZZ: q_zz <= prod[Q_W-1:0];
          OP_TXX: t_xx <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_TXY: t_xy <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_TXZ: t_xz <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_TYY: t_yy <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_TYZ: t_yz <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_TZZ: t_zz <= prod[T_SHIFT+TQ_W-1:T_SHIFT];
          OP_M0, OP_M3, OP_M6: acc <= ROW_ROUND + prod[ACC_W-1:0];
          OP_M1, OP_M4, OP_M7: acc <= acc + prod[ACC_W-1:0];
          OP_M2, OP_M5, OP_M8: begin
            rowsum <= acc + prod[ACC_W-1:0];
            fin_v  <= 1'b1;
            fin_op <= op_d;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Row result: drop to Q16, add the position back and saturate.
  always_comb begin
    unique case (fin_op)
      OP_M2:   pos_sel = pos_x;
      OP_M5:   pos_sel = pos_y;
      default: pos_sel = pos_z;
    endcase
    fin_sum = FIN_W'(rowsum >>> ROW_SHIFT) + FIN_W'(pos_sel);
    fin_sat = sat_coord(fin_sum);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      start_view_x <= '0;
      start_view_y <= '0;
      start_view_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_X:        pos_x        <= cfg_data;
        REG_POS_Y:        pos_y        <= cfg_data;
        REG_POS_Z:        pos_z        <= cfg_data;
        REG_START_VIEW_X: start_view_x <= cfg_data;
        REG_START_VIEW_Y: start_view_y <= cfg_data;
        REG_START_VIEW_Z: start_view_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stored view point: reloaded on any register write, updated row by row.
  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= '0;
      view_y <= '0;
      view_z <= '0;
    end else if (cfg_reload) begin
      view_x <= (cfg_index == REG_START_VIEW_X) ? cfg_data : start_view_x;
      view_y <= (cfg_index == REG_START_VIEW_Y) ? cfg_data : start_view_y;
      view_z <= (cfg_index == REG_START_VIEW_Z) ? cfg_data : start_view_z;
    end else if (fin_v) begin
      unique case (fin_op)
        OP_M2:   view_x <= fin_sat;
        OP_M5:   view_y <= fin_sat;
        OP_M8:   view_z <= fin_sat;
        default: begin
        end
      endcase
    end
  end

  // Output register, loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!out_valid || !out_stall)) begin
      new_view_x <= view_x;
      new_view_y <= view_y;
      new_view_z <= view_z;
    end
  end

endmodule

FILE: hw/rtl/aavr_checker.sv
// Port-level checker for axis_angle_view_rotation_core, attached by a bind statement.
// Depends on assert_macros.svh and on the core's port names.
`include "assert_macros.svh"

module aavr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] new_view_x,
  input logic [31:0] new_view_y,
  input logic [31:0] new_view_z
);

  logic        req_acc;
  logic        held;
  logic [95:0] view_bus;

  // Handshake terms and the presented result as one bus.
  assign req_acc  = in_valid && !in_stall;
  assign held     = out_valid && out_stall;
  assign view_bus = {new_view_x, new_view_y, new_view_z};

  // A stalled result stays presented and unchanged.
  `AAVR_ASSERT_NXT(a_out_hold, held, out_valid && $stable(view_bus), "stalled result changed")

  // After a request is taken the core works on it alone.
  `AAVR_ASSERT_NXT(a_busy_after_req, req_acc, in_stall, "core free right after a request")

  // A result never appears in the cycle right after a request.
  `AAVR_ASSERT_NXT(a_no_instant_result, req_acc, !$rose(out_valid), "result too early")

  // When a new result appears, the core is free for the next request.
  `AAVR_ASSERT_IMP(a_free_with_result, $rose(out_valid), !in_stall, "core busy with result")

endmodule

bind axis_angle_view_rotation_core aavr_checker u_aavr_checker (.*);
